/* rtl/core/iol_pkg.sv */
package iol_pkg;

	// list geometry
	localparam int CAPACITY      = 16;
	localparam int ELEMENT_WIDTH = 32;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int IDX_W         = $clog2(CAPACITY);

	// limit register
	localparam logic [4:0] LIMIT_RESET = 5'd16;

	// operation codes
	localparam logic [1:0] OP_GET    = 2'd0;
	localparam logic [1:0] OP_LOCATE = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	typedef logic [ELEMENT_WIDTH-1:0] elem_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         position;
		logic signed [31:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic               ok;
		logic [3:0]         found_position;
		logic signed [31:0] read_value;
		logic [4:0]         length;
		logic               is_empty;
		logic               is_full;
	} rsp_item_t;

	// controller to datapath strobes
	typedef struct packed {
		logic load;
		logic exec;
		logic emit;
	} ctl_cmd_t;

	// keep the low element bits of a sign-extended input value
	function automatic elem_t to_elem(input logic signed [31:0] v);
		logic [63:0] ext;
		ext = 64'(v);
		return ext[ELEMENT_WIDTH-1:0];
	endfunction

	// sign-extend an element and keep 32 bits
	function automatic logic [31:0] from_elem(input elem_t e);
		logic [63:0] ext;
		ext = 64'(signed'(e));
		return ext[31:0];
	endfunction

endpackage

/* rtl/core/iol_cmd_if.sv */
interface iol_cmd_if import iol_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/iol_rsp_if.sv */
interface iol_rsp_if import iol_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/iol_ctrl.sv */
module iol_ctrl import iol_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ctl_cmd_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// sequence one item: capture, execute, emit
	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		ctl.emit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// advance state and hold the output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/iol_datapath.sv */
module iol_datapath import iol_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   ctl,
	input  cmd_item_t  cmd_item,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	output rsp_item_t  rsp_item
);

	elem_t              entries_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic [4:0]         limit_q;
	logic [1:0]         op_q;
	logic [3:0]         pos_q;
	elem_t              val_q;
	logic [CAPACITY-1:0] match_q;
	logic               ok_q;
	logic [31:0]        rd_q;
	rsp_item_t          rsp_q;

	logic [CNT_W-1:0]   lim;
	logic               pos_lt_cnt;
	logic               pos_le_cnt;
	logic               ins_ok;
	logic               del_ok;
	logic [CAPACITY-1:0] match;
	logic [3:0]         fpos;

	assign rsp_item = rsp_q;

	// clamp the limit to 1..CAPACITY
	always_comb begin
		if (limit_q == 5'd0) begin
			lim = CNT_W'(1);
		end else if (32'(limit_q) > CAPACITY) begin
			lim = CNT_W'(CAPACITY);
		end else begin
			lim = CNT_W'(limit_q);
		end
	end

	assign pos_lt_cnt = 32'(pos_q) < 32'(count_q);
	assign pos_le_cnt = 32'(pos_q) <= 32'(count_q);
	assign ins_ok     = (count_q < lim) && pos_le_cnt;
	assign del_ok     = (count_q != '0) && pos_lt_cnt;

	// compare every live cell against the search value
	always_comb begin
		for (int j = 0; j < CAPACITY; j++) begin
			match[j] = (32'(j) < 32'(count_q)) && (entries_q[j] == val_q);
		end
	end

	// pick the lowest matching cell
	always_comb begin
		fpos = 4'd0;
		for (int j = CAPACITY - 1; j >= 0; j--) begin
			if (match_q[j]) begin
				fpos = 4'(j);
			end
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.exec) begin
			if (op_q == OP_INSERT && ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (op_q == OP_DELETE && del_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= cmd_item.operation;
			pos_q <= cmd_item.position;
			val_q <= to_elem(cmd_item.value);
		end
	end

	// shift the cell row up on insert, down on delete
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			for (int j = 0; j < CAPACITY; j++) begin
				if (op_q == OP_INSERT && ins_ok) begin
					if (32'(j) == 32'(pos_q)) begin
						entries_q[j] <= val_q;
					end else if (j > 0 && 32'(j) > 32'(pos_q)) begin
						entries_q[j] <= entries_q[(j > 0) ? j - 1 : 0];
					end
				end else if (op_q == OP_DELETE && del_ok) begin
					if (j < CAPACITY - 1 && 32'(j) >= 32'(pos_q)) begin
						entries_q[j] <= entries_q[(j < CAPACITY - 1) ? j + 1 : j];
					end
				end
			end
		end
	end

	// register match flags, status and read data
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			match_q <= match;
			rd_q    <= (op_q == OP_GET && pos_lt_cnt) ?
				from_elem(entries_q[IDX_W'(pos_q)]) : 32'd0;
			case (op_q)
				OP_GET:    ok_q <= pos_lt_cnt;
				OP_LOCATE: ok_q <= 1'b0;
				OP_INSERT: ok_q <= ins_ok;
				OP_DELETE: ok_q <= del_ok;
				default:   ok_q <= 1'b0;
			endcase
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			rsp_q.ok             <= (op_q == OP_LOCATE) ? (|match_q) : ok_q;
			rsp_q.found_position <= (op_q == OP_LOCATE) ? fpos : 4'd0;
			rsp_q.read_value     <= rd_q;
			rsp_q.length         <= 5'(count_q);
			rsp_q.is_empty       <= (count_q == '0);
			rsp_q.is_full        <= (count_q >= lim);
		end
	end

endmodule

/* rtl/core/indexed_ordered_list_top.sv */
// channel  dir  handshake      payload
// cmd      in   valid/ready    operation, position, value
// rsp      out  valid/ready    ok, found_position, read_value, length, is_empty, is_full
// cfg      in   cfg_we         cfg_wdata = list limit (5 bits)
//
// Each item passes through capture, execute over the cell row, and emit;
// the emit waits until the output register is free, and the next item is
// taken in the cycle after the emit.
// A stalled output holds the result register and the item waits in emit.
// Reset clears the length and sets the limit to 16; cell contents are not cleared.
module indexed_ordered_list_top import iol_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	iol_cmd_if.sink    cmd,
	iol_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	ctl_cmd_t ctl;

	iol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	iol_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd_item  (cmd.payload),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_item  (rsp.payload)
	);

endmodule
